// ----- rtl/core/bffd_pkg.sv -----
// shared types and codes for the budgeted first-fit dispatcher
`default_nettype none

package bffd_pkg;

    localparam int unsigned NEED_BITS = 32;

    // input opcodes
    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_QUEUED     = 3'd0;
    localparam logic [2:0] STAT_TOO_LARGE  = 3'd1;
    localparam logic [2:0] STAT_FULL       = 3'd2;
    localparam logic [2:0] STAT_DISPATCHED = 3'd3;
    localparam logic [2:0] STAT_NONE_FITS  = 3'd4;
    localparam logic [2:0] STAT_EMPTY      = 3'd5;
    localparam logic [2:0] STAT_RELEASED   = 3'd6;

    localparam logic [NEED_BITS-1:0] LIMIT_RESET = 32'd1024;

    // request to the shared add/subtract unit
    typedef struct packed {
        logic                 sub;
        logic [NEED_BITS:0]   a;
        logic [NEED_BITS:0]   b;
    } alu_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/budgeted_first_fit_dispatcher.sv -----
// budgeted first-fit job queue with a shared adder and a sequencer over a job memory
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: opcode, tdata: job_tag, amount
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser: status, tdata: result fields
//  cfg       in   cfg_wr_en                      cfg_wr_data: resource_limit
//
// enqueue checks the job, then writes it; release adds, then clamps to the limit;
// dispatch on an empty queue responds directly, else it reads and compares each entry
// scanned, then moves up each entry after the picked one over the single read port.
// s_axis_tready is high only in idle; a stalled result holds the sequencer in its
// response step. synchronous active-low reset, no clearing pass is needed.
`default_nettype none

module budgeted_first_fit_dispatcher #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TAG_BITS    = 16
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [1:0]  s_axis_tuser,   // opcode
    input  wire  [47:0] s_axis_tdata,   // job_tag[15:0], amount[47:16]

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [2:0]  m_axis_tuser,   // status
    output logic [87:0] m_axis_tdata,   // picked_tag, picked_need, budget_left,
                                        // queue_count, release_clamped

    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data
);
    import bffd_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = NEED_BITS + TAG_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENQ      = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_SHIFT_RD = 4'd4;
    localparam logic [3:0] S_SHIFT_WR = 4'd5;
    localparam logic [3:0] S_REL_ADD  = 4'd6;
    localparam logic [3:0] S_REL_CMP  = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [NEED_BITS-1:0] limit_reg, limit_next;
    logic [NEED_BITS-1:0] budget_reg, budget_next;
    logic [NEED_BITS-1:0] amt_reg, amt_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [NEED_BITS:0]   sum_reg, sum_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]  res_tag_reg, res_tag_next;
    logic [NEED_BITS-1:0] res_need_reg, res_need_next;
    logic                 res_clamp_reg, res_clamp_next;
    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_status_reg, m_status_next;
    logic [87:0]          m_data_reg, m_data_next;

    // job memory, need above tag
    logic [EW-1:0]        job_mem [QUEUE_DEPTH];
    logic [EW-1:0]        rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;

    alu_req_t             alu_req;
    logic [NEED_BITS+1:0] alu_res;
    logic                 alu_borrow;

    logic [CW:0]          idx_inc;
    logic [CW:0]          count_wide;
    logic [TAG_BITS+15:0] in_tag_wide;
    logic [TAG_BITS+15:0] out_tag_wide;
    logic [CW+6:0]        count_out_wide;
    logic [NEED_BITS-1:0] rd_need;
    logic [TAG_BITS-1:0]  rd_tag;
    logic                 out_free;

    bffd_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign alu_borrow     = alu_res[NEED_BITS+1];
    assign idx_inc        = {1'b0, idx_reg} + (CW+1)'(1);
    assign count_wide     = {1'b0, count_reg};
    assign in_tag_wide    = {{TAG_BITS{1'b0}}, s_axis_tdata[15:0]};
    assign out_tag_wide   = {16'b0, res_tag_reg};
    assign count_out_wide = {7'b0, count_reg};
    assign rd_need        = rd_data_reg[EW-1:TAG_BITS];
    assign rd_tag         = rd_data_reg[TAG_BITS-1:0];
    assign out_free       = !m_valid_reg || m_axis_tready;

    assign s_axis_tready  = (state_reg == S_IDLE);
    assign m_axis_tvalid  = m_valid_reg;
    assign m_axis_tuser   = m_status_reg;
    assign m_axis_tdata   = m_data_reg;

    // shared unit operand selection
    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            S_ENQ: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, limit_reg};
                alu_req.b   = {1'b0, amt_reg};
            end
            S_SCAN_CMP: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, budget_reg};
                alu_req.b   = {1'b0, rd_need};
            end
            S_REL_ADD: begin
                alu_req.sub = 1'b0;
                alu_req.a   = {1'b0, budget_reg};
                alu_req.b   = {1'b0, amt_reg};
            end
            S_REL_CMP: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, limit_reg};
                alu_req.b   = sum_reg;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        limit_next      = limit_reg;
        budget_next     = budget_reg;
        amt_next        = amt_reg;
        tag_next        = tag_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_need_next   = res_need_reg;
        res_clamp_next  = res_clamp_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = rd_data_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    amt_next        = s_axis_tdata[47:16];
                    tag_next        = in_tag_wide[TAG_BITS-1:0];
                    idx_next        = '0;
                    res_tag_next    = '0;
                    res_need_next   = '0;
                    res_clamp_next  = 1'b0;
                    unique case (s_axis_tuser)
                        OP_ENQUEUE:  state_next = S_ENQ;
                        OP_DISPATCH: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_RELEASE:  state_next = S_REL_ADD;
                        default:     state_next = S_IDLE;  // unused opcode, no result
                    endcase
                end
            end
            S_ENQ: begin
                if (alu_borrow) begin
                    res_status_next = STAT_TOO_LARGE;
                end else if (count_wide >= (CW+1)'(QUEUE_DEPTH)) begin
                    res_status_next = STAT_FULL;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[AW-1:0];
                    wr_data         = {amt_reg, tag_reg};
                    count_next      = count_reg + CW'(1);
                    res_status_next = STAT_QUEUED;
                end
                state_next = S_RESP;
            end
            S_SCAN_RD: begin
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (!alu_borrow) begin
                    budget_next     = alu_res[NEED_BITS-1:0];
                    res_status_next = STAT_DISPATCHED;
                    res_tag_next    = rd_tag;
                    res_need_next   = rd_need;
                    count_next      = count_reg - CW'(1);
                    // close the gap left by the picked job
                    state_next      = (idx_inc < count_wide) ? S_SHIFT_RD : S_RESP;
                end else if (idx_inc < count_wide) begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = S_SCAN_RD;
                end else begin
                    res_status_next = STAT_NONE_FITS;
                    state_next      = S_RESP;
                end
            end
            S_SHIFT_RD: begin
                rd_addr    = idx_inc[AW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // count already holds the reduced total here
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_data_reg;
                idx_next   = idx_inc[CW-1:0];
                state_next = (idx_inc < count_wide) ? S_SHIFT_RD : S_RESP;
            end
            S_REL_ADD: begin
                sum_next   = alu_res[NEED_BITS:0];
                state_next = S_REL_CMP;
            end
            S_REL_CMP: begin
                if (alu_borrow) begin
                    budget_next    = limit_reg;
                    res_clamp_next = 1'b1;
                end else begin
                    budget_next = sum_reg[NEED_BITS-1:0];
                end
                res_status_next = STAT_RELEASED;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = {res_clamp_reg, count_out_wide[6:0], budget_reg,
                                     res_need_reg, out_tag_wide[15:0]};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // limit write reloads the budget
        if (cfg_wr_en) begin
            limit_next  = cfg_wr_data;
            budget_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            budget_reg  <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            budget_reg  <= budget_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        amt_reg        <= amt_next;
        tag_reg        <= tag_next;
        sum_reg        <= sum_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_need_reg   <= res_need_next;
        res_clamp_reg  <= res_clamp_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            job_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= job_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_wide <= (CW+1)'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_budget_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        budget_reg <= limit_reg)
        else $error("remaining budget above limit");

    a_idle_pick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != STAT_DISPATCHED) |->
            (m_axis_tdata[47:0] == 48'd0))
        else $error("picked fields set on a result that dispatched nothing");

    a_release_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REL_ADD) |=> (state_reg == S_REL_CMP) && $stable(count_reg))
        else $error("release sequence broken");

endmodule

`default_nettype wire

// ----- rtl/core/bffd_alu.sv -----
// shared add/subtract unit, the top bit of the result is the borrow or carry
`default_nettype none

module bffd_alu (
    input  var bffd_pkg::alu_req_t                 req,
    output logic [bffd_pkg::NEED_BITS+1:0]         res
);
    import bffd_pkg::*;

    logic [NEED_BITS+1:0] a_ext;
    logic [NEED_BITS+1:0] b_ext;

    assign a_ext = {1'b0, req.a};
    assign b_ext = {1'b0, req.b};
    assign res   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);

endmodule

`default_nettype wire
